// ----- hdl/stq_pkg.sv -----
// Shared types and codes for the sorted timeout queue.
package stq_pkg;

    // Request opcodes
    localparam logic [1:0] OP_SLEEP  = 2'd0;
    localparam logic [1:0] OP_CANCEL = 2'd1;
    localparam logic [1:0] OP_TICK   = 2'd2;

    // Result kinds
    localparam logic [1:0] KIND_INSERT = 2'd0;
    localparam logic [1:0] KIND_CANCEL = 2'd1;
    localparam logic [1:0] KIND_WAKE   = 2'd2;

    // Result status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_REJECT    = 2'd2;

    // Most threads woken by one tick
    localparam int MAX_RESULTS = 32;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INS_SCAN,
        S_INS_SHIFT,
        S_CAN_SCAN,
        S_TICK_SCAN,
        S_COMPACT
    } state_t;

endpackage

// ----- hdl/stq_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module stq_ram #(
    parameter int WIDTH = 40,
    parameter int DEPTH = 32
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ----- hdl/sorted_timeout_queue_core.sv -----
// Sorted timeout queue: sequencer around one entry memory holding {wake time, thread}.
//
// A rejected insert on a full queue answers in the cycle after the request.
// Otherwise an insert scans every entry, then shifts the tail up to make room;
// a cancel scans for the thread, then compacts the entries behind the removed slot;
// a tick wakes one thread per cycle and then compacts the queue.
// Each result sits on the ports in the cycle after the one that produces it; paced by the
// single read and single write port of the entry memory, one request at a time.
// Reset clears the tick counter and entry count; the entry memory itself is not cleared.
module sorted_timeout_queue_core #(
    parameter int MAX_SLEEPERS   = 32,
    parameter int THREAD_ID_BITS = 8
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic [1:0]                op,
    input  logic [THREAD_ID_BITS-1:0] thread_id,
    input  logic [30:0]               duration_ticks,
    output logic                      strobe,
    output logic [1:0]                kind,
    output logic [THREAD_ID_BITS-1:0] thread_out,
    output logic [1:0]                status,
    output logic [31:0]               remaining_ticks,
    output logic                      last
);

    import stq_pkg::*;

    localparam int AW      = (MAX_SLEEPERS > 1) ? $clog2(MAX_SLEEPERS) : 1;
    localparam int CW      = $clog2(MAX_SLEEPERS + 1);
    localparam int EW      = 32 + THREAD_ID_BITS;
    localparam int RES_LIM = (MAX_RESULTS < MAX_SLEEPERS) ? MAX_RESULTS : MAX_SLEEPERS;

    // Sequencer state
    state_t                    state_reg, state_next;
    logic [CW-1:0]             count_reg, count_next;
    logic [31:0]               now_reg, now_next;
    logic [THREAD_ID_BITS-1:0] tid_reg, tid_next;
    logic [30:0]               dur_reg, dur_next;

    // Memory walk: rd_idx is the next slot to read, rv marks data returning this cycle
    logic [CW-1:0]             rd_idx_reg, rd_idx_next;
    logic                      rv_reg, rv_next;
    logic [CW-1:0]             rv_idx_reg, rv_idx_next;

    // Scan results and compaction distance
    logic [CW-1:0]             pos_reg, pos_next;
    logic                      found_reg, found_next;
    logic                      dup_reg, dup_next;
    logic [CW-1:0]             shift_reg, shift_next;

    // Woken thread held back so that the final one can carry last
    logic                      pend_v_reg, pend_v_next;
    logic [THREAD_ID_BITS-1:0] pend_id_reg, pend_id_next;

    // Result registers
    logic                      strobe_reg, strobe_next;
    logic [1:0]                kind_reg, kind_next;
    logic [THREAD_ID_BITS-1:0] tout_reg, tout_next;
    logic [1:0]                status_reg, status_next;
    logic [31:0]               rem_reg, rem_next;
    logic                      last_reg, last_next;

    // Memory port
    logic                      ram_we, ram_re;
    logic [AW-1:0]             ram_waddr, ram_raddr;
    logic [EW-1:0]             ram_wdata, ram_rdata;

    // Entry decode and datapath helpers
    logic [31:0]               q_wake;
    logic [THREAD_ID_BITS-1:0] q_id;
    logic [31:0]               wake_delta;
    logic [31:0]               q_key;
    logic [31:0]               new_key;
    logic                      q_due;
    logic [CW-1:0]             lim;
    logic [CW-1:0]             rd_dec;
    logic [CW-1:0]             rd_inc;
    logic [CW-1:0]             rv_inc;
    logic [CW-1:0]             rv_sub;

    stq_ram #(
        .WIDTH (EW),
        .DEPTH (MAX_SLEEPERS)
    ) u_entries (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign q_wake     = ram_rdata[EW-1:THREAD_ID_BITS];
    assign q_id       = ram_rdata[THREAD_ID_BITS-1:0];
    // Signed distance from now; ordering key biases it for an unsigned compare
    assign wake_delta = q_wake - now_reg;
    assign q_key      = {~wake_delta[31], wake_delta[30:0]};
    assign new_key    = {1'b1, dur_reg};
    assign q_due      = (wake_delta == 32'd0) || wake_delta[31];
    assign lim        = (count_reg > CW'(RES_LIM)) ? CW'(RES_LIM) : count_reg;
    assign rd_dec     = rd_idx_reg - 1'b1;
    assign rd_inc     = rd_idx_reg + 1'b1;
    assign rv_inc     = rv_idx_reg + 1'b1;
    assign rv_sub     = rv_idx_reg - shift_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            count_reg  <= '0;
            now_reg    <= '0;
            rv_reg     <= 1'b0;
            pend_v_reg <= 1'b0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            now_reg    <= now_next;
            rv_reg     <= rv_next;
            pend_v_reg <= pend_v_next;
            strobe_reg <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tid_reg     <= tid_next;
        dur_reg     <= dur_next;
        rd_idx_reg  <= rd_idx_next;
        rv_idx_reg  <= rv_idx_next;
        pos_reg     <= pos_next;
        found_reg   <= found_next;
        dup_reg     <= dup_next;
        shift_reg   <= shift_next;
        pend_id_reg <= pend_id_next;
        kind_reg    <= kind_next;
        tout_reg    <= tout_next;
        status_reg  <= status_next;
        rem_reg     <= rem_next;
        last_reg    <= last_next;
    end

    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        now_next     = now_reg;
        tid_next     = tid_reg;
        dur_next     = dur_reg;
        rd_idx_next  = rd_idx_reg;
        rv_next      = 1'b0;
        rv_idx_next  = rv_idx_reg;
        pos_next     = pos_reg;
        found_next   = found_reg;
        dup_next     = dup_reg;
        shift_next   = shift_reg;
        pend_v_next  = pend_v_reg;
        pend_id_next = pend_id_reg;
        strobe_next  = 1'b0;
        kind_next    = kind_reg;
        tout_next    = tout_reg;
        status_next  = status_reg;
        rem_next     = rem_reg;
        last_next    = last_reg;
        ram_we       = 1'b0;
        ram_waddr    = '0;
        ram_wdata    = '0;
        ram_re       = 1'b0;
        ram_raddr    = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    tid_next    = thread_id;
                    dur_next    = duration_ticks;
                    rd_idx_next = '0;
                    found_next  = 1'b0;
                    dup_next    = 1'b0;
                    pend_v_next = 1'b0;
                    priority if (op == OP_SLEEP)
                    begin
                        if (count_reg == CW'(MAX_SLEEPERS))
                        begin
                            strobe_next = 1'b1;
                            kind_next   = KIND_INSERT;
                            tout_next   = thread_id;
                            status_next = ST_REJECT;
                            rem_next    = '0;
                            last_next   = 1'b1;
                        end
                        else
                        begin
                            pos_next   = count_reg;
                            state_next = S_INS_SCAN;
                        end
                    end
                    else if (op == OP_CANCEL)
                    begin
                        state_next = S_CAN_SCAN;
                    end
                    else if (op == OP_TICK)
                    begin
                        now_next   = now_reg + 32'd1;
                        state_next = S_TICK_SCAN;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end

            S_INS_SCAN:
            begin
                // Full walk: duplicate check plus first slot with a later key
                if (rd_idx_reg < count_reg)
                begin
                    ram_re      = 1'b1;
                    ram_raddr   = rd_idx_reg[AW-1:0];
                    rd_idx_next = rd_inc;
                    rv_next     = 1'b1;
                    rv_idx_next = rd_idx_reg;
                end
                if (rv_reg)
                begin
                    if (q_id == tid_reg)
                    begin
                        dup_next = 1'b1;
                    end
                    if (!found_reg && (q_key > new_key))
                    begin
                        found_next = 1'b1;
                        pos_next   = rv_idx_reg;
                    end
                end
                if ((rd_idx_reg == count_reg) && !rv_reg)
                begin
                    if (dup_reg)
                    begin
                        strobe_next = 1'b1;
                        kind_next   = KIND_INSERT;
                        tout_next   = tid_reg;
                        status_next = ST_REJECT;
                        rem_next    = '0;
                        last_next   = 1'b1;
                        state_next  = S_IDLE;
                    end
                    else
                    begin
                        rd_idx_next = count_reg;
                        state_next  = S_INS_SHIFT;
                    end
                end
            end

            S_INS_SHIFT:
            begin
                // Move the tail up one slot, top entry first, then drop the new one in
                if (rd_idx_reg > pos_reg)
                begin
                    ram_re      = 1'b1;
                    ram_raddr   = rd_dec[AW-1:0];
                    rd_idx_next = rd_dec;
                    rv_next     = 1'b1;
                    rv_idx_next = rd_dec;
                end
                if (rv_reg)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = rv_inc[AW-1:0];
                    ram_wdata = ram_rdata;
                end
                if ((rd_idx_reg == pos_reg) && !rv_reg)
                begin
                    ram_we      = 1'b1;
                    ram_waddr   = pos_reg[AW-1:0];
                    ram_wdata   = {now_reg + {1'b0, dur_reg}, tid_reg};
                    count_next  = count_reg + 1'b1;
                    strobe_next = 1'b1;
                    kind_next   = KIND_INSERT;
                    tout_next   = tid_reg;
                    status_next = ST_OK;
                    rem_next    = '0;
                    last_next   = 1'b1;
                    state_next  = S_IDLE;
                end
            end

            S_CAN_SCAN:
            begin
                if (rd_idx_reg < count_reg)
                begin
                    ram_re      = 1'b1;
                    ram_raddr   = rd_idx_reg[AW-1:0];
                    rd_idx_next = rd_inc;
                    rv_next     = 1'b1;
                    rv_idx_next = rd_idx_reg;
                end
                if (rv_reg && (q_id == tid_reg))
                begin
                    // Found: report now, then close the gap behind it
                    strobe_next = 1'b1;
                    kind_next   = KIND_CANCEL;
                    tout_next   = tid_reg;
                    status_next = ST_OK;
                    rem_next    = wake_delta;
                    last_next   = 1'b1;
                    shift_next  = CW'(1);
                    rd_idx_next = rv_inc;
                    rv_next     = 1'b0;
                    state_next  = S_COMPACT;
                end
                else if ((rd_idx_reg == count_reg) && !rv_reg)
                begin
                    strobe_next = 1'b1;
                    kind_next   = KIND_CANCEL;
                    tout_next   = tid_reg;
                    status_next = ST_NOT_FOUND;
                    rem_next    = '0;
                    last_next   = 1'b1;
                    state_next  = S_IDLE;
                end
            end

            S_TICK_SCAN:
            begin
                if (rd_idx_reg < lim)
                begin
                    ram_re      = 1'b1;
                    ram_raddr   = rd_idx_reg[AW-1:0];
                    rd_idx_next = rd_inc;
                    rv_next     = 1'b1;
                    rv_idx_next = rd_idx_reg;
                end
                if (rv_reg && q_due)
                begin
                    if (pend_v_reg)
                    begin
                        strobe_next = 1'b1;
                        kind_next   = KIND_WAKE;
                        tout_next   = pend_id_reg;
                        status_next = ST_OK;
                        rem_next    = '0;
                        last_next   = 1'b0;
                    end
                    pend_v_next  = 1'b1;
                    pend_id_next = q_id;
                end
                else if (rv_reg || (rd_idx_reg == lim))
                begin
                    // Head run ends here; number woken equals the index reached
                    rv_next = 1'b0;
                    if (pend_v_reg)
                    begin
                        strobe_next = 1'b1;
                        kind_next   = KIND_WAKE;
                        tout_next   = pend_id_reg;
                        status_next = ST_OK;
                        rem_next    = '0;
                        last_next   = 1'b1;
                        pend_v_next = 1'b0;
                        shift_next  = rv_reg ? rv_idx_reg : rd_idx_reg;
                        rd_idx_next = rv_reg ? rv_idx_reg : rd_idx_reg;
                        state_next  = S_COMPACT;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end

            S_COMPACT:
            begin
                // Move entries from rd_idx onwards down by shift slots
                if (rd_idx_reg < count_reg)
                begin
                    ram_re      = 1'b1;
                    ram_raddr   = rd_idx_reg[AW-1:0];
                    rd_idx_next = rd_inc;
                    rv_next     = 1'b1;
                    rv_idx_next = rd_idx_reg;
                end
                if (rv_reg)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = rv_sub[AW-1:0];
                    ram_wdata = ram_rdata;
                end
                if ((rd_idx_reg == count_reg) && !rv_reg)
                begin
                    count_next = count_reg - shift_reg;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy            = (state_reg != S_IDLE);
    assign strobe          = strobe_reg;
    assign kind            = kind_reg;
    assign thread_out      = tout_reg;
    assign status          = status_reg;
    assign remaining_ticks = rem_reg;
    assign last            = last_reg;

    // Occupancy never runs past the memory depth
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(MAX_SLEEPERS))
    else $error("entry count beyond capacity");

    // Only a woken thread can be followed by further results of the same request
    a_last_kind: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && !last) |-> (kind == KIND_WAKE))
    else $error("non-final result that is not a wake-up");

    // A tick request advances the counter by exactly one
    a_tick_adv: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (op == OP_TICK)) |=> (now_reg == $past(now_reg) + 32'd1))
    else $error("tick counter not advanced");

    // Shifts never read and write the same slot in one cycle
    a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
        !(ram_we && ram_re && (ram_waddr == ram_raddr)))
    else $error("entry memory read and write collide");

endmodule
